[design/assert_macros.svh]
// Assertion macros shared by the depth-to-point-cloud RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, held off while reset is low.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication, held off while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[design/d2pc_pkg.sv]
// Shared widths, constants, register codes and types for the depth-to-point-cloud block.
package d2pc_pkg;

    // field widths
    localparam int DEPTH_W  = 16;
    localparam int PIX_W    = 12;
    localparam int COLOR_W  = 8;
    localparam int COORD_W  = 32;
    localparam int SCALE_W  = 16;
    localparam int FOCAL_W  = 24;
    localparam int CENTER_W = 20;
    localparam int SUBPIX_W = 8;    // Q.8 fraction of intrinsics
    localparam int QFRAC_W  = 16;   // Q16.16 fraction of outputs

    // image bounds
    localparam int MAX_COLUMNS = 4096;
    localparam int MAX_ROWS    = 4096;

    // derived datapath widths
    localparam int MAG_W      = PIX_W + SUBPIX_W;         // |pixel*256 - center|
    localparam int PROD_W     = MAG_W + DEPTH_W;          // magnitude * depth
    localparam int HI_W       = PROD_W - QFRAC_W;         // numerator bits above the quotient
    localparam int DEN_XY_W   = SCALE_W + FOCAL_W;        // scale * focal
    localparam int DIV_STEPS  = COORD_W;                  // quotient bits, one per stage

    // saturation limits of a signed Q16.16 coordinate
    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

    // register reset values
    localparam logic [SCALE_W-1:0]  DEPTH_SCALE_RST = SCALE_W'(5000);
    localparam logic [FOCAL_W-1:0]  FOCAL_X_RST     = FOCAL_W'(134400);
    localparam logic [FOCAL_W-1:0]  FOCAL_Y_RST     = FOCAL_W'(134400);
    localparam logic [CENTER_W-1:0] CENTER_X_RST    = CENTER_W'(81792);
    localparam logic [CENTER_W-1:0] CENTER_Y_RST    = CENTER_W'(61312);

    // APB port
    localparam int APB_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int APB_ADDR_W = CFG_IDX_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEPTH_SCALE = 3'd0,
        REG_FOCAL_X     = 3'd1,
        REG_FOCAL_Y     = 3'd2,
        REG_CENTER_X    = 3'd3,
        REG_CENTER_Y    = 3'd4
    } t_cfg_reg;

    // per-item data that rides alongside the dividers
    typedef struct packed {
        logic               neg_x;
        logic               neg_y;
        logic               ovf_x;
        logic               ovf_y;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } t_side;

    // one finished point
    typedef struct packed {
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic [COORD_W-1:0] point_z;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } t_point;

endpackage

[design/d2pc_in_if.sv]
// Depth pixel stream channel: valid/ready plus depth, position and color.
interface d2pc_in_if;
    import d2pc_pkg::*;

    logic               valid;
    logic               ready;
    logic [DEPTH_W-1:0] depth_raw;
    logic [PIX_W-1:0]   pixel_column;
    logic [PIX_W-1:0]   pixel_row;
    logic [COLOR_W-1:0] blue_in;
    logic [COLOR_W-1:0] green_in;
    logic [COLOR_W-1:0] red_in;

    modport source (
        output valid, depth_raw, pixel_column, pixel_row, blue_in, green_in, red_in,
        input  ready
    );

    modport sink (
        input  valid, depth_raw, pixel_column, pixel_row, blue_in, green_in, red_in,
        output ready
    );
endinterface

[design/d2pc_out_if.sv]
// Point stream channel: valid/ready plus Q16.16 coordinates and color.
interface d2pc_out_if;
    import d2pc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [COORD_W-1:0]        point_z;
    logic [COLOR_W-1:0]        blue_out;
    logic [COLOR_W-1:0]        green_out;
    logic [COLOR_W-1:0]        red_out;

    modport source (
        output valid, point_x, point_y, point_z, blue_out, green_out, red_out,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, point_z, blue_out, green_out, red_out,
        output ready
    );
endinterface

[design/d2pc_div.sv]
// Pipelined restoring divider: one quotient bit per register stage.
module d2pc_div #(
    parameter int DEN_W = d2pc_pkg::DEN_XY_W,
    parameter int STEPS = d2pc_pkg::DIV_STEPS
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DEN_W-1:0] i_rem,   // leading partial remainder, below i_den
    input  logic [STEPS-1:0] i_low,   // dividend bits still to bring down, MSB first
    input  logic [DEN_W-1:0] i_den,   // divisor, nonzero, static while items flow
    output logic [STEPS-1:0] o_quo
);

    logic [DEN_W-1:0] r_rem [STEPS];
    logic [STEPS-1:0] r_low [STEPS];
    logic [STEPS-1:0] r_quo [STEPS];

    // stage inputs: first stage from ports, others from the previous stage
    logic [DEN_W-1:0] src_rem [STEPS];
    logic [STEPS-1:0] src_low [STEPS];
    logic [STEPS-1:0] src_quo [STEPS];

    logic [DEN_W-1:0] n_rem [STEPS];
    logic [STEPS-1:0] n_low [STEPS];
    logic [STEPS-1:0] n_quo [STEPS];

    assign src_rem[0] = i_rem;
    assign src_low[0] = i_low;
    assign src_quo[0] = '0;

    for (genvar s = 0; s < STEPS; s++) begin : g_stage
        logic [DEN_W:0]   trial;
        logic [DEN_W+1:0] diff;
        logic             fits;

        if (s > 0) begin : g_link
            assign src_rem[s] = r_rem[s-1];
            assign src_low[s] = r_low[s-1];
            assign src_quo[s] = r_quo[s-1];
        end

        // bring down one bit, trial subtract, keep the inverted borrow as the quotient bit
        always_comb begin
            trial    = {src_rem[s], src_low[s][STEPS-1]};
            diff     = {1'b0, trial} - {2'b00, i_den};
            fits     = ~diff[DEN_W+1];
            n_rem[s] = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            n_low[s] = {src_low[s][STEPS-2:0], 1'b0};
            n_quo[s] = {src_quo[s][STEPS-2:0], fits};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem[s];
                r_low[s] <= n_low[s];
                r_quo[s] <= n_quo[s];
            end
        end
    end

    assign o_quo = r_quo[STEPS-1];

endmodule

[design/depth_to_point_cloud_core.sv]
// Depth-to-point-cloud core: back-projects depth pixels through a pinhole camera model.
// Accepts one depth pixel per clock and returns one point per clock while the output is not
// held off. Between input beat and output beat lie three front stages (offset from the
// principal point, multiply by depth, overflow check), three 32-stage pipelined long
// dividers, one quotient bit per stage, that run side by side for x, y and z, and the output
// register. Pixels with zero depth or outside the image produce no beat; each leaves a
// one-cycle hole in the output stream. When the output is held off, one finished point
// waits in the output register and a second in a skid register; input ready drops while
// the skid register is full and the whole pipeline freezes until it drains. The APB
// registers are to be written while no pixel is in flight; reads return the stored values.
`include "assert_macros.svh"

module depth_to_point_cloud_core #(
    parameter int MAX_COLUMNS = d2pc_pkg::MAX_COLUMNS,
    parameter int MAX_ROWS    = d2pc_pkg::MAX_ROWS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    d2pc_in_if.sink                         i_pix,
    d2pc_out_if.source                      o_pt,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [d2pc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [d2pc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [d2pc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import d2pc_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [SCALE_W-1:0]  r_depth_scale;
    logic [FOCAL_W-1:0]  r_focal_x;
    logic [FOCAL_W-1:0]  r_focal_y;
    logic [CENTER_W-1:0] r_center_x;
    logic [CENTER_W-1:0] r_center_y;
    logic                cfg_wr;
    t_cfg_reg            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = t_cfg_reg'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_scale <= DEPTH_SCALE_RST;
            r_focal_x     <= FOCAL_X_RST;
            r_focal_y     <= FOCAL_Y_RST;
            r_center_x    <= CENTER_X_RST;
            r_center_y    <= CENTER_Y_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_DEPTH_SCALE: r_depth_scale <= pwdata[SCALE_W-1:0];
                REG_FOCAL_X:     r_focal_x     <= pwdata[FOCAL_W-1:0];
                REG_FOCAL_Y:     r_focal_y     <= pwdata[FOCAL_W-1:0];
                REG_CENTER_X:    r_center_x    <= pwdata[CENTER_W-1:0];
                REG_CENTER_Y:    r_center_y    <= pwdata[CENTER_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (cfg_idx)
            REG_DEPTH_SCALE: prdata = APB_DATA_W'(r_depth_scale);
            REG_FOCAL_X:     prdata = APB_DATA_W'(r_focal_x);
            REG_FOCAL_Y:     prdata = APB_DATA_W'(r_focal_y);
            REG_CENTER_X:    prdata = APB_DATA_W'(r_center_x);
            REG_CENTER_Y:    prdata = APB_DATA_W'(r_center_y);
            default:         prdata = '0;
        endcase
    end

    // zero divisors act as one; divisor products are static between config writes
    logic [SCALE_W-1:0]  scale_eff;
    logic [FOCAL_W-1:0]  fx_eff;
    logic [FOCAL_W-1:0]  fy_eff;
    logic [DEN_XY_W-1:0] r_den_x;
    logic [DEN_XY_W-1:0] r_den_y;

    assign scale_eff = (r_depth_scale == '0) ? SCALE_W'(1) : r_depth_scale;
    assign fx_eff    = (r_focal_x == '0) ? FOCAL_W'(1) : r_focal_x;
    assign fy_eff    = (r_focal_y == '0) ? FOCAL_W'(1) : r_focal_y;

    always_ff @(posedge i_clk) begin
        r_den_x <= DEN_XY_W'(scale_eff) * DEN_XY_W'(fx_eff);
        r_den_y <= DEN_XY_W'(scale_eff) * DEN_XY_W'(fy_eff);
    end

    // ------------------------------------------------------------------
    // pipeline enable: whole pipeline moves unless the skid register is full
    // ------------------------------------------------------------------
    logic r_main_valid;
    logic r_skid_valid;
    logic pipe_en;

    assign pipe_en     = ~r_skid_valid;
    assign i_pix.ready = pipe_en;

    // ------------------------------------------------------------------
    // stage A: filter, offset from principal point
    // ------------------------------------------------------------------
    logic                in_beat;
    logic                keep;
    logic [MAG_W:0]      diff_x;
    logic [MAG_W:0]      diff_y;
    t_side               a_side;
    logic [MAG_W-1:0]    a_mag_x;
    logic [MAG_W-1:0]    a_mag_y;

    logic                r_a_valid;
    logic [DEPTH_W-1:0]  r_a_depth;
    logic [MAG_W-1:0]    r_a_mag_x;
    logic [MAG_W-1:0]    r_a_mag_y;
    t_side               r_a_side;

    assign in_beat = i_pix.valid & pipe_en;
    assign keep    = (i_pix.depth_raw != '0)
                   && (32'(i_pix.pixel_column) < 32'(MAX_COLUMNS))
                   && (32'(i_pix.pixel_row) < 32'(MAX_ROWS));

    always_comb begin
        diff_x  = {1'b0, i_pix.pixel_column, {SUBPIX_W{1'b0}}} - {1'b0, r_center_x};
        diff_y  = {1'b0, i_pix.pixel_row, {SUBPIX_W{1'b0}}} - {1'b0, r_center_y};
        a_mag_x = diff_x[MAG_W] ? (MAG_W'(0) - diff_x[MAG_W-1:0]) : diff_x[MAG_W-1:0];
        a_mag_y = diff_y[MAG_W] ? (MAG_W'(0) - diff_y[MAG_W-1:0]) : diff_y[MAG_W-1:0];
        a_side       = '0;
        a_side.neg_x = diff_x[MAG_W];
        a_side.neg_y = diff_y[MAG_W];
        a_side.blue  = i_pix.blue_in;
        a_side.green = i_pix.green_in;
        a_side.red   = i_pix.red_in;
    end

    // ------------------------------------------------------------------
    // stage B: magnitude times depth
    // ------------------------------------------------------------------
    logic                r_b_valid;
    logic [PROD_W-1:0]   r_b_prod_x;
    logic [PROD_W-1:0]   r_b_prod_y;
    logic [DEPTH_W-1:0]  r_b_depth;
    t_side               r_b_side;

    // ------------------------------------------------------------------
    // stage C: quotient overflow check, divider operands
    // ------------------------------------------------------------------
    logic [HI_W-1:0]     hi_x;
    logic [HI_W-1:0]     hi_y;
    logic                ovf_x;
    logic                ovf_y;
    t_side               c_side;

    logic                r_c_valid;
    logic [DEN_XY_W-1:0] r_c_rem_x;
    logic [DEN_XY_W-1:0] r_c_rem_y;
    logic [COORD_W-1:0]  r_c_low_x;
    logic [COORD_W-1:0]  r_c_low_y;
    logic [COORD_W-1:0]  r_c_low_z;
    t_side               r_c_side;

    // quotient reaches 2^32 exactly when the numerator bits above it reach the divisor
    always_comb begin
        hi_x  = r_b_prod_x[PROD_W-1:QFRAC_W];
        hi_y  = r_b_prod_y[PROD_W-1:QFRAC_W];
        ovf_x = DEN_XY_W'(hi_x) >= r_den_x;
        ovf_y = DEN_XY_W'(hi_y) >= r_den_y;
        c_side       = r_b_side;
        c_side.ovf_x = ovf_x;
        c_side.ovf_y = ovf_y;
    end

    // front stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (pipe_en) begin
            r_a_valid <= in_beat & keep;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // front stage payload
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_a_depth  <= i_pix.depth_raw;
            r_a_mag_x  <= a_mag_x;
            r_a_mag_y  <= a_mag_y;
            r_a_side   <= a_side;

            r_b_prod_x <= PROD_W'(r_a_mag_x) * PROD_W'(r_a_depth);
            r_b_prod_y <= PROD_W'(r_a_mag_y) * PROD_W'(r_a_depth);
            r_b_depth  <= r_a_depth;
            r_b_side   <= r_a_side;

            r_c_rem_x  <= ovf_x ? '0 : DEN_XY_W'(hi_x);
            r_c_rem_y  <= ovf_y ? '0 : DEN_XY_W'(hi_y);
            r_c_low_x  <= {r_b_prod_x[QFRAC_W-1:0], {(COORD_W-QFRAC_W){1'b0}}};
            r_c_low_y  <= {r_b_prod_y[QFRAC_W-1:0], {(COORD_W-QFRAC_W){1'b0}}};
            r_c_low_z  <= {r_b_depth, {(COORD_W-DEPTH_W){1'b0}}};
            r_c_side   <= c_side;
        end
    end

    // ------------------------------------------------------------------
    // dividers
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] quo_x;
    logic [COORD_W-1:0] quo_y;
    logic [COORD_W-1:0] quo_z;

    d2pc_div #(.DEN_W(DEN_XY_W), .STEPS(DIV_STEPS)) u_div_x (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_rem (r_c_rem_x),
        .i_low (r_c_low_x),
        .i_den (r_den_x),
        .o_quo (quo_x)
    );

    d2pc_div #(.DEN_W(DEN_XY_W), .STEPS(DIV_STEPS)) u_div_y (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_rem (r_c_rem_y),
        .i_low (r_c_low_y),
        .i_den (r_den_y),
        .o_quo (quo_y)
    );

    // z = depth * 65536 / scale never exceeds 32 bits, remainder starts at zero
    d2pc_div #(.DEN_W(SCALE_W), .STEPS(DIV_STEPS)) u_div_z (
        .i_clk (i_clk),
        .i_en  (pipe_en),
        .i_rem ('0),
        .i_low (r_c_low_z),
        .i_den (scale_eff),
        .o_quo (quo_z)
    );

    // side line matching divider latency
    logic [DIV_STEPS-1:0] r_vld;
    t_side                r_line [DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[DIV_STEPS-2:0], r_c_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_line[0] <= r_c_side;
            for (int s = 1; s < DIV_STEPS; s++) begin
                r_line[s] <= r_line[s-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // sign and saturation
    // ------------------------------------------------------------------
    function automatic logic [COORD_W-1:0] f_signed_sat(
        input logic               neg,
        input logic               ovf,
        input logic [COORD_W-1:0] q
    );
        logic big;
        big = ovf | q[COORD_W-1];
        if (neg) begin
            f_signed_sat = big ? COORD_MIN : (COORD_W'(0) - q);
        end else begin
            f_signed_sat = big ? COORD_MAX : q;
        end
    endfunction

    t_side  last_side;
    t_point core_pt;
    logic   push;

    assign last_side = r_line[DIV_STEPS-1];
    assign push      = pipe_en & r_vld[DIV_STEPS-1];

    always_comb begin
        core_pt.point_x = f_signed_sat(last_side.neg_x, last_side.ovf_x, quo_x);
        core_pt.point_y = f_signed_sat(last_side.neg_y, last_side.ovf_y, quo_y);
        core_pt.point_z = quo_z;
        core_pt.blue    = last_side.blue;
        core_pt.green   = last_side.green;
        core_pt.red     = last_side.red;
    end

    // ------------------------------------------------------------------
    // output register plus skid register
    // ------------------------------------------------------------------
    t_point r_main;
    t_point r_skid;
    logic   pop;
    logic   n_main_valid;
    logic   n_skid_valid;
    logic   load_main_core;
    logic   load_main_skid;
    logic   load_skid;

    assign pop = r_main_valid & o_pt.ready;

    always_comb begin
        n_main_valid   = r_main_valid;
        n_skid_valid   = r_skid_valid;
        load_main_core = 1'b0;
        load_main_skid = 1'b0;
        load_skid      = 1'b0;
        if (r_skid_valid) begin
            // pipeline frozen, drain the skid beat first
            if (pop) begin
                load_main_skid = 1'b1;
                n_skid_valid   = 1'b0;
            end
        end else if (push) begin
            if (!r_main_valid || pop) begin
                load_main_core = 1'b1;
                n_main_valid   = 1'b1;
            end else begin
                load_skid    = 1'b1;
                n_skid_valid = 1'b1;
            end
        end else if (pop) begin
            n_main_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_main_core) begin
            r_main <= core_pt;
        end else if (load_main_skid) begin
            r_main <= r_skid;
        end
        if (load_skid) begin
            r_skid <= core_pt;
        end
    end

    assign o_pt.valid     = r_main_valid;
    assign o_pt.point_x   = $signed(r_main.point_x);
    assign o_pt.point_y   = $signed(r_main.point_y);
    assign o_pt.point_z   = r_main.point_z;
    assign o_pt.blue_out  = r_main.blue;
    assign o_pt.green_out = r_main.green;
    assign o_pt.red_out   = r_main.red;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPLY(a_skid_behind_main, i_clk, i_rst_n, r_skid_valid, r_main_valid)
    `ASSERT_NEXT(a_stall_freezes_line, i_clk, i_rst_n, !pipe_en, $stable(r_vld))
    `ASSERT_NEXT(a_zero_depth_dropped, i_clk, i_rst_n, i_pix.valid && i_pix.ready && (i_pix.depth_raw == '0), !r_a_valid)
    `ASSERT_NEXT(a_blocked_push_to_skid, i_clk, i_rst_n, push && r_main_valid && !o_pt.ready, r_skid_valid)
    `ASSERT_IMPLY(a_point_z_nonzero, i_clk, i_rst_n, r_main_valid, r_main.point_z != '0)

endmodule
